FILE: rtl/core/stx_etx_frame_receiver_core_defines.svh
// ---------------------------------------------------------------------------
// stx/etx frame receiver assertion macros
// shared macros for the concurrent checks of the receiver core
// ---------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_RECEIVER_CORE_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_CORE_DEFINES_SVH

// condition and consequence in the same cycle
`define STXFR_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("stxfr check failed");

// consequence in the cycle after the condition
`define STXFR_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("stxfr check failed");

`endif

FILE: rtl/core/stxfr_pkg.sv
// ---------------------------------------------------------------------------
// stxfr_pkg
// types and constants shared by the stx/etx frame receiver modules
// ---------------------------------------------------------------------------
package stxfr_pkg;

  // frame hunting phase, one-hot
  typedef enum logic [3:0] {
    HUNT_START = 4'b0001,
    HUNT_OP    = 4'b0010,
    HUNT_LEN   = 4'b0100,
    HUNT_DATA  = 4'b1000
  } hunt_t;

  // result status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_BAD_OP   = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // item kinds
  localparam logic KIND_RECEIVE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // operation digit range, ascii '0' to '5'
  localparam logic [7:0] OP_DIGIT_LO = 8'h30;
  localparam logic [7:0] OP_DIGIT_HI = 8'h35;

  // register index, taken from paddr[2]
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  // reset values of the registers
  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  // write request into the frame store
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } store_wr_t;

endpackage

FILE: rtl/core/stx_etx_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// stx_etx_frame_receiver_core
// start/end delimited frame receiver with length check and byte buffer
// ---------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    kind, rx_byte, read_index
// out      output     out_valid / out_stall  status, op_code, data_length,
//                                            frame_length, read_data
// cfg      input      apb (psel, penable)    start_byte, end_byte
//
// one transaction per cycle while the result is not stalled, through an input
// register, then the parse step and buffer access into the result register
// the buffer has a single write port and a single read port, one access each
// per cycle
// reset is synchronous; the buffer is not cleared and needs no sweep
// a stalled result holds while one more transaction waits in the input register
// ---------------------------------------------------------------------------
`include "stx_etx_frame_receiver_core_defines.svh"

module stx_etx_frame_receiver_core #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic [5:0]  read_index,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  op_code,
  output logic [7:0]  data_length,
  output logic [5:0]  frame_length,
  output logic [7:0]  read_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stxfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic            s1_valid;
  logic            s1_kind;
  logic [7:0]      s1_rx_byte;
  logic [5:0]      s1_read_index;
  logic            advance;
  logic            commit;
  logic            rd_sel;
  logic [AW+5:0]   rd_pad;
  logic [7:0]      start_byte;
  logic [7:0]      end_byte;
  logic [2:0]      parse_status;
  store_wr_t       wr;
  logic [AW-1:0]   wr_addr;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      end_byte   <= END_BYTE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_START_BYTE: start_byte <= pwdata[7:0];
        REG_END_BYTE:   end_byte   <= pwdata[7:0];
        default:        start_byte <= start_byte;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START_BYTE: prdata = {24'b0, start_byte};
      REG_END_BYTE:   prdata = {24'b0, end_byte};
      default:        prdata = '0;
    endcase
  end

  // handshake: result register frees when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign commit   = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind       <= kind;
      s1_rx_byte    <= rx_byte;
      s1_read_index <= read_index;
    end
  end

  // parse step
  stxfr_parse #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (commit && (s1_kind == KIND_RECEIVE)),
    .rx_byte      (s1_rx_byte),
    .start_byte   (start_byte),
    .end_byte     (end_byte),
    .status       (parse_status),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .op_code      (op_code),
    .data_length  (data_length),
    .frame_length (frame_length)
  );

  // frame buffer
  assign rd_sel = (s1_kind == KIND_READ) && (32'(s1_read_index) < BUFFER_DEPTH);
  assign rd_pad = {{AW{1'b0}}, s1_read_index};

  stxfr_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_go     (commit && (s1_kind == KIND_RECEIVE)),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .load      (commit),
    .rd_sel    (rd_sel),
    .rd_addr   (rd_pad[AW-1:0]),
    .read_data (read_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status <= (s1_kind == KIND_RECEIVE) ? parse_status : ST_NONE;
    end
  end

  // checks
  `STXFR_ASSERT_NEXT(a_commit_fills_out, clk, rst, commit, out_valid)
  `STXFR_ASSERT_NEXT(a_drain_empties_out, clk, rst, out_valid && !out_stall && !s1_valid, !out_valid)
  `STXFR_ASSERT_NOW(a_done_length, clk, rst, out_valid && (status == ST_DONE), frame_length == 6'(data_length + 8'd3))

endmodule

FILE: rtl/core/stxfr_parse.sv
// ---------------------------------------------------------------------------
// stxfr_parse
// frame hunting state and per-byte decision logic of the receiver
// ---------------------------------------------------------------------------
module stxfr_parse #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  rx_byte,
  input  logic [7:0]                  start_byte,
  input  logic [7:0]                  end_byte,
  output logic [2:0]                  status,
  output stxfr_pkg::store_wr_t        wr,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [2:0]                  op_code,
  output logic [7:0]                  data_length,
  output logic [5:0]                  frame_length
);
  import stxfr_pkg::*;

  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int WI_W = $clog2(BUFFER_DEPTH + 1);

  hunt_t            hunt, hunt_next;
  logic [WI_W-1:0]  write_index, write_index_next;
  logic [WI_W-1:0]  data_count, data_count_next;
  logic [7:0]       declared_length, declared_length_next;
  logic [2:0]       pending_op, pending_op_next;
  logic [2:0]       last_op, last_op_next;
  logic [7:0]       last_length, last_length_next;
  logic [WI_W-1:0]  last_frame_length, last_frame_length_next;
  logic             store_ok;
  logic             bad_digit;
  logic [WI_W+5:0]  flen_pad;

  assign store_ok  = 32'(write_index) < BUFFER_DEPTH;
  assign bad_digit = (rx_byte < OP_DIGIT_LO) || (rx_byte > OP_DIGIT_HI);
  assign wr_addr   = write_index[AW-1:0];

  // per-byte decision
  always_comb begin
    hunt_next              = hunt;
    write_index_next       = write_index;
    data_count_next        = data_count;
    declared_length_next   = declared_length;
    pending_op_next        = pending_op;
    last_op_next           = last_op;
    last_length_next       = last_length;
    last_frame_length_next = last_frame_length;
    status                 = ST_NONE;
    wr.en                  = 1'b0;
    wr.data                = rx_byte;
    unique case (hunt)
      HUNT_START: begin
        if (rx_byte == start_byte) begin
          wr.en            = 1'b1;
          write_index_next = WI_W'(1);
          data_count_next  = '0;
          hunt_next        = HUNT_OP;
        end
      end
      HUNT_OP: begin
        if (bad_digit) begin
          status = ST_BAD_OP;
        end else if (!store_ok) begin
          status = ST_OVERFLOW;
        end else begin
          wr.en            = 1'b1;
          write_index_next = write_index + WI_W'(1);
          pending_op_next  = 3'(rx_byte - OP_DIGIT_LO);
          hunt_next        = HUNT_LEN;
        end
      end
      HUNT_LEN: begin
        if (!store_ok) begin
          status = ST_OVERFLOW;
        end else begin
          wr.en                = 1'b1;
          write_index_next     = write_index + WI_W'(1);
          declared_length_next = rx_byte;
          data_count_next      = '0;
          hunt_next            = HUNT_DATA;
        end
      end
      HUNT_DATA: begin
        if (rx_byte != end_byte) begin
          if (!store_ok) begin
            status = ST_OVERFLOW;
          end else begin
            wr.en            = 1'b1;
            write_index_next = write_index + WI_W'(1);
            data_count_next  = data_count + WI_W'(1);
          end
        end else if (32'(data_count) != 32'(declared_length)) begin
          status = ST_MISMATCH;
        end else if (!store_ok) begin
          status = ST_OVERFLOW;
        end else begin
          wr.en                  = 1'b1;
          last_frame_length_next = write_index;
          last_op_next           = pending_op;
          last_length_next       = declared_length;
          status                 = ST_DONE;
        end
      end
      default: begin
        hunt_next = HUNT_START;
      end
    endcase
    // any error or completion drops the frame in progress
    if (status != ST_NONE) begin
      hunt_next        = HUNT_START;
      write_index_next = '0;
      data_count_next  = '0;
    end
  end

  // state registers, updated once per received byte
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt              <= HUNT_START;
      write_index       <= '0;
      data_count        <= '0;
      declared_length   <= '0;
      pending_op        <= '0;
      last_op           <= '0;
      last_length       <= '0;
      last_frame_length <= '0;
    end else if (step) begin
      hunt              <= hunt_next;
      write_index       <= write_index_next;
      data_count        <= data_count_next;
      declared_length   <= declared_length_next;
      pending_op        <= pending_op_next;
      last_op           <= last_op_next;
      last_length       <= last_length_next;
      last_frame_length <= last_frame_length_next;
    end
  end

  // last accepted frame, frame length masked to six bits
  assign flen_pad     = {6'b0, last_frame_length};
  assign frame_length = flen_pad[5:0];
  assign op_code      = last_op;
  assign data_length  = last_length;

endmodule

FILE: rtl/core/stxfr_store.sv
// ---------------------------------------------------------------------------
// stxfr_store
// frame byte buffer with one write port and one registered read port
// ---------------------------------------------------------------------------
module stxfr_store #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_go,
  input  stxfr_pkg::store_wr_t            wr,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  logic                            load,
  input  logic                            rd_sel,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output logic [7:0]                      read_data
);
  import stxfr_pkg::*;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_q;
  logic       rd_hit;

  // byte write
  always_ff @(posedge clk) begin
    if (wr_go && wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // registered read, loaded with the result register
  always_ff @(posedge clk) begin
    if (load && rd_sel) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (load) begin
      rd_hit <= rd_sel;
    end
  end

  // receive items and reads beyond the buffer give zero
  assign read_data = rd_hit ? rd_q : 8'h00;

endmodule

FILE: sim/stx_etx_frame_receiver_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stx_etx_frame_receiver_core_tb
// drives received bytes and buffer reads into the frame receiver, predicts
// every result with a cycle-free parser model and compares field by field
// ---------------------------------------------------------------------------
module stx_etx_frame_receiver_core_tb;
  import stxfr_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int HOLD_CYCLES = 80;

  // one result transaction
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] op_code;
    logic [7:0] data_length;
    logic [5:0] frame_length;
    logic [7:0] read_data;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  rx_byte;
  logic [5:0]  read_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [2:0]  op_code;
  logic [7:0]  data_length;
  logic [5:0]  frame_length;
  logic [7:0]  read_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // parser model state
  logic [7:0]  parse_start_byte;
  logic [7:0]  parse_end_byte;
  hunt_t       parse_phase;
  int          parse_wr_pos;
  logic [7:0]  parse_decl_len;
  int          parse_data_cnt;
  logic [2:0]  parse_pend_op;
  logic [2:0]  last_frame_op;
  logic [7:0]  last_frame_len;
  logic [5:0]  last_frame_end_pos;
  logic [7:0]  frame_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] stored_mask;

  frame_result_t pending_results[$];
  int            error_count;
  int            items_sent;
  bit            tx_gaps_on;
  bit            rx_stalls_on;
  bit            hold_req;

  stx_etx_frame_receiver_core #(
    .BUFFER_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .rx_byte     (rx_byte),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .op_code     (op_code),
    .data_length (data_length),
    .frame_length(frame_length),
    .read_data   (read_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // ------------------------------------------------------------------------
  // parser model
  // ------------------------------------------------------------------------
  function automatic void restart_hunt();
    parse_phase    = HUNT_START;
    parse_wr_pos   = 0;
    parse_data_cnt = 0;
  endfunction

  function automatic bit store_frame_byte(logic [7:0] b);
    if (parse_wr_pos >= STORE_DEPTH) return 1'b0;
    frame_mem[parse_wr_pos]   = b;
    stored_mask[parse_wr_pos] = 1'b1;
    parse_wr_pos++;
    return 1'b1;
  endfunction

  function automatic void reset_parser();
    parse_start_byte   = START_BYTE_RST;
    parse_end_byte     = END_BYTE_RST;
    parse_decl_len     = '0;
    parse_pend_op      = '0;
    last_frame_op      = '0;
    last_frame_len     = '0;
    last_frame_end_pos = '0;
    stored_mask        = '0;
    restart_hunt();
  endfunction

  function automatic frame_result_t next_frame_result(logic k, logic [7:0] b,
                                                      logic [5:0] idx);
    frame_result_t r;
    logic [5:0]    end_pos;
    r = '0;
    r.status = ST_NONE;
    if (k == KIND_READ) begin
      if (stored_mask[idx]) r.read_data = frame_mem[idx];
    end else begin
      case (parse_phase)
        HUNT_START: begin
          if (b == parse_start_byte) begin
            restart_hunt();
            void'(store_frame_byte(b));
            parse_phase = HUNT_OP;
          end
        end
        HUNT_OP: begin
          if (b < OP_DIGIT_LO || b > OP_DIGIT_HI) begin
            restart_hunt();
            r.status = ST_BAD_OP;
          end else if (!store_frame_byte(b)) begin
            restart_hunt();
            r.status = ST_OVERFLOW;
          end else begin
            parse_pend_op = 3'(b - OP_DIGIT_LO);
            parse_phase   = HUNT_LEN;
          end
        end
        HUNT_LEN: begin
          if (!store_frame_byte(b)) begin
            restart_hunt();
            r.status = ST_OVERFLOW;
          end else begin
            parse_decl_len = b;
            parse_data_cnt = 0;
            parse_phase    = HUNT_DATA;
          end
        end
        default: begin
          if (b != parse_end_byte) begin
            if (!store_frame_byte(b)) begin
              restart_hunt();
              r.status = ST_OVERFLOW;
            end else begin
              parse_data_cnt++;
            end
          end else if (parse_data_cnt != int'(parse_decl_len)) begin
            // end byte with a wrong data count is never stored
            restart_hunt();
            r.status = ST_MISMATCH;
          end else begin
            end_pos = parse_wr_pos[5:0];
            if (!store_frame_byte(b)) begin
              restart_hunt();
              r.status = ST_OVERFLOW;
            end else begin
              last_frame_end_pos = end_pos;
              last_frame_op      = parse_pend_op;
              last_frame_len     = parse_decl_len;
              restart_hunt();
              r.status = ST_DONE;
            end
          end
        end
      endcase
    end
    r.op_code      = last_frame_op;
    r.data_length  = last_frame_len;
    r.frame_length = last_frame_end_pos;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // input channel driver
  // ------------------------------------------------------------------------
  task automatic send_item(logic k, logic [7:0] b, logic [5:0] idx);
    bit took;
    bit ignored;
    // random sender gap
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    rx_byte    <= b;
    read_index <= idx;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    ignored = (k == KIND_RECEIVE) && (parse_phase == HUNT_START) &&
              (b != parse_start_byte);
    if (!ignored) items_sent++;
    pending_results.push_back(next_frame_result(k, b, idx));
  endtask

  task automatic send_rx(logic [7:0] b);
    send_item(KIND_RECEIVE, b, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_read(logic [5:0] idx);
    send_item(KIND_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // read a buffer position that has been written before
  task automatic send_random_read();
    int idx;
    if (stored_mask == '0) return;
    do idx = $urandom_range(0, STORE_DEPTH - 1); while (!stored_mask[idx]);
    send_read(6'(idx));
  endtask

  // start, op, length, n data bytes and optionally the end byte, with random reads mixed in
  task automatic send_frame(logic [7:0] op_byte, logic [7:0] len_byte, int n_data,
                            bit with_end);
    logic [7:0] b;
    send_rx(parse_start_byte);
    if ($urandom_range(0, 9) == 0) send_random_read();
    send_rx(op_byte);
    send_rx(len_byte);
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(0, 9) == 0) send_random_read();
      do b = 8'($urandom_range(0, 255)); while (b == parse_end_byte);
      send_rx(b);
    end
    if (with_end) send_rx(parse_end_byte);
  endtask

  // stop offering and let every expected result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------------
  task automatic write_reg(logic sel, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    if (sel == REG_START_BYTE) parse_start_byte = value;
    else parse_end_byte = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(logic sel, logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    if (prdata[7:0] !== want)
      report_error($sformatf("register %0d read %0h expected %0h", sel, prdata[7:0],
                             want));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delimiters(logic [7:0] s, logic [7:0] e);
    wait_idle();
    write_reg(REG_START_BYTE, s);
    write_reg(REG_END_BYTE, e);
    read_reg(REG_START_BYTE, s);
    read_reg(REG_END_BYTE, e);
  endtask

  // ------------------------------------------------------------------------
  // output channel: stall generator and result checker
  // ------------------------------------------------------------------------
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    frame_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_error("result transaction with no expectation");
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_error($sformatf("status %0d expected %0d", status, want.status));
          if (op_code !== want.op_code)
            report_error($sformatf("op_code %0d expected %0d", op_code, want.op_code));
          if (data_length !== want.data_length)
            report_error($sformatf("data_length %0d expected %0d", data_length,
                                   want.data_length));
          if (frame_length !== want.frame_length)
            report_error($sformatf("frame_length %0d expected %0d", frame_length,
                                   want.frame_length));
          if (read_data !== want.read_data)
            report_error($sformatf("read_data %0h expected %0h", read_data,
                                   want.read_data));
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_reset_values();
    read_reg(REG_START_BYTE, START_BYTE_RST);
    read_reg(REG_END_BYTE, END_BYTE_RST);
  endtask

  // short frames, operation extremes, bad operations, length mismatch
  task automatic test_directed_frames();
    // bytes while hunting are ignored
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(parse_end_byte);
    // empty frame, lowest operation
    send_rx(parse_start_byte);
    send_rx(OP_DIGIT_LO);
    send_rx(8'h00);
    send_rx(parse_end_byte);
    // completion lasts one transaction only
    send_read(6'd0);
    // highest operation with extreme data bytes
    send_rx(parse_start_byte);
    send_rx(OP_DIGIT_HI);
    send_rx(8'd2);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(parse_end_byte);
    send_read(6'd3);
    send_read(6'd4);
    // operation bytes just outside the digit range
    send_rx(parse_start_byte);
    send_rx(OP_DIGIT_LO - 8'd1);
    send_rx(parse_start_byte);
    send_rx(OP_DIGIT_HI + 8'd1);
    // end byte with too few data bytes
    send_rx(parse_start_byte);
    send_rx(OP_DIGIT_LO + 8'd3);
    send_rx(8'd1);
    send_rx(parse_end_byte);
  endtask

  task automatic test_buffer_overflow();
    // count matches but the end byte has no room
    send_frame(OP_DIGIT_LO + 8'd1, 8'd61, 61, 1'b1);
    // end byte at a full buffer with a wrong count is a mismatch
    send_frame(OP_DIGIT_LO + 8'd2, 8'd0, 61, 1'b1);
    // data byte beyond the buffer
    send_frame(OP_DIGIT_LO + 8'd3, 8'd255, 62, 1'b0);
    // largest frame that still fits
    send_frame(OP_DIGIT_LO + 8'd4, 8'd60, 60, 1'b1);
    send_read(6'd63);
    send_read(6'd62);
    send_read(6'd0);
  endtask

  task automatic test_delimiter_extremes();
    set_delimiters(8'h00, 8'hFF);
    send_frame(OP_DIGIT_LO + 8'd2, 8'd4, 4, 1'b1);
    set_delimiters(8'hFF, 8'h00);
    send_frame(OP_DIGIT_HI, 8'd1, 1, 1'b1);
    send_rx(8'hFF);
    send_rx(8'hFF);
    // same value opens and closes a frame
    set_delimiters(8'h7E, 8'h7E);
    send_frame(OP_DIGIT_LO + 8'd1, 8'd2, 2, 1'b1);
    send_frame(OP_DIGIT_LO, 8'd0, 0, 1'b1);
  endtask

  // mostly good frames with random content, some broken ones and noise
  task automatic test_random_traffic(bit random_delims, int target);
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] b;
    int         pick;
    int         len;
    if (random_delims) begin
      s = 8'($urandom_range(0, 255));
      do e = 8'($urandom_range(0, 255)); while (e == s);
    end else begin
      s = START_BYTE_RST;
      e = END_BYTE_RST;
    end
    set_delimiters(s, e);
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(11, 60);
      else len = $urandom_range(0, 10);
      if (pick < 65) begin
        send_frame(8'(OP_DIGIT_LO + $urandom_range(0, 5)), 8'(len), len, 1'b1);
      end else if (pick < 75) begin
        // wrong number of data bytes
        send_frame(8'(OP_DIGIT_LO + $urandom_range(0, 5)), 8'(len),
                   (len > 0 && $urandom_range(0, 1)) ? len - 1 :
                   len + $urandom_range(1, 3), 1'b1);
      end else if (pick < 82) begin
        do b = 8'($urandom_range(0, 255));
        while (b >= OP_DIGIT_LO && b <= OP_DIGIT_HI);
        send_rx(parse_start_byte);
        send_rx(b);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) send_random_read();
      end
    end
  endtask

  // long receiver hold-off while frames keep coming
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_req     = 1'b1;
    repeat (6) send_frame(8'(OP_DIGIT_LO + $urandom_range(0, 5)), 8'd3, 3, 1'b1);
    wait_idle();
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    error_count  = 0;
    items_sent   = 0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_req     = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_RECEIVE;
    rx_byte      = '0;
    read_index   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    reset_parser();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed_frames();
    test_buffer_overflow();
    test_delimiter_extremes();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    test_random_traffic(1'b0, 380);
    test_random_traffic(1'b1, 520);
    test_backpressure();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    test_random_traffic(1'b1, 700);
    // closing stretch without any idling
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    test_random_traffic(1'b1, 850);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
